>>> design/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg
// Shared types and constants of the echo reply tracker: channel items,
// status codes, ICMP type codes, register indexes and time constants.
// ----------------------------------------------------------------------------
package erc_pkg;

  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SUM_W      = 48;

  // Result status codes.
  localparam logic [1:0] STATUS_SENT      = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED  = 2'd1;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
  localparam logic [1:0] STATUS_REJECTED  = 2'd3;

  // Input function codes.
  localparam logic FUNC_SEND    = 1'b0;
  localparam logic FUNC_RECEIVE = 1'b1;

  // ICMP message types.
  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DATA_LENGTH    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IDENTIFIER = 8'd1;

  localparam logic [15:0] DATA_LENGTH_RESET = 16'd32;
  localparam logic [15:0] OWN_IDENT_RESET   = 16'd0;
  localparam int unsigned HEADER_BYTES      = 8;

  // Time constants.
  localparam int unsigned USEC_PER_SEC   = 1000000;
  localparam int unsigned TENTHS_PER_SEC = 10000;
  localparam int unsigned USEC_PER_TENTH = 100;
  localparam int unsigned TENTHS_PER_MS  = 10;

  // Reciprocal for the microsecond to tenth-of-millisecond division. It is
  // exact for every dividend below 2^20.
  localparam int unsigned RECIP_SHIFT = 27;
  localparam int unsigned RECIP_TENTH =
    ((1 << RECIP_SHIFT) + USEC_PER_TENTH - 1) / USEC_PER_TENTH;

  typedef struct packed {
    logic        func;
    logic [15:0] total_length;
    logic [7:0]  msg_type;
    logic [15:0] icmp_ident;
    logic [15:0] icmp_sequence;
    logic [31:0] stamp_sec;
    logic [19:0] stamp_usec;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
    logic [31:0] send_ms;
    logic [31:0] recv_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      trip_time;
    logic [15:0]      sent_sequence;
    logic [31:0]      sent_total;
    logic [31:0]      received_total;
    logic [31:0]      duplicate_total;
    logic [31:0]      minimum_trip;
    logic [31:0]      maximum_trip;
    logic [SUM_W-1:0] trip_sum;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_item_t;

endpackage

>>> design/erc_stream_if.sv
// ----------------------------------------------------------------------------
// erc_stream_if
// Valid/ready channel carrying one item of a chosen payload type.
// ----------------------------------------------------------------------------
interface erc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/erc_ram.sv
// ----------------------------------------------------------------------------
// erc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module erc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/erc_slot.sv
// ----------------------------------------------------------------------------
// erc_slot
// Reduces a 16-bit sequence number modulo the duplicate window size.
// ----------------------------------------------------------------------------
module erc_slot #(
  parameter int unsigned WINDOW = 1024
) (
  input  logic [15:0]                value,
  output logic [$clog2(WINDOW)-1:0]  slot
);

  localparam int unsigned SW = $clog2(WINDOW);
  localparam logic [SW:0] WIN_L = (SW+1)'(WINDOW);

  logic [SW-1:0] hi_tbl [256];
  logic [SW-1:0] lo_tbl [256];
  logic [SW:0]   part_sum;

  // Each byte is reduced by its own table; the two residues sum below twice
  // the window, so a single conditional subtract finishes the job.
  for (genvar g = 0; g < 256; g = g + 1) begin : g_tbl
    assign hi_tbl[g] = SW'((g * 256) % WINDOW);
    assign lo_tbl[g] = SW'(g % WINDOW);
  end

  always_comb begin
    part_sum = {1'b0, hi_tbl[value[15:8]]} + {1'b0, lo_tbl[value[7:0]]};
    if (part_sum >= WIN_L) begin
      part_sum = part_sum - WIN_L;
    end
    slot = part_sum[SW-1:0];
  end

endmodule

>>> design/erc_trip.sv
// ----------------------------------------------------------------------------
// erc_trip
// Round-trip time in tenths of a millisecond, from the embedded timestamp
// for echo replies or from the millisecond stamps for time-exceeded ones.
// ----------------------------------------------------------------------------
module erc_trip (
  input  erc_pkg::in_item_t item,
  input  logic              echo_sel,
  output logic [31:0]       trip
);
  import erc_pkg::*;

  localparam logic signed [20:0] USEC_WRAP = 21'(USEC_PER_SEC);
  localparam logic [20:0]        RECIP_L   = 21'(RECIP_TENTH);

  logic signed [20:0] du;
  logic signed [20:0] du_adj;
  logic               borrow;
  logic               du_neg;
  logic [19:0]        du_abs;
  logic [40:0]        recip_prod;
  logic [13:0]        tenths;
  logic [31:0]        tenths_ext;
  logic [31:0]        ds;
  logic [31:0]        echo_trip;
  logic [31:0]        ms_diff;
  logic [31:0]        te_trip;

  always_comb begin
    du     = $signed({1'b0, item.now_usec}) - $signed({1'b0, item.stamp_usec});
    borrow = du[20];
    du_adj = borrow ? du + USEC_WRAP : du;
    du_neg = du_adj[20];
    du_abs = du_neg ? 20'(-du_adj) : du_adj[19:0];

    // Division by 100 truncates toward zero, so the magnitude is divided and
    // the sign put back afterwards.
    recip_prod = {21'd0, du_abs} * {20'd0, RECIP_L};
    tenths     = recip_prod[RECIP_SHIFT +: 14];
    tenths_ext = du_neg ? -{18'd0, tenths} : {18'd0, tenths};

    ds        = item.now_sec - item.stamp_sec - {31'd0, borrow};
    echo_trip = ds * 32'(TENTHS_PER_SEC) + tenths_ext;

    ms_diff = item.recv_ms - item.send_ms;
    te_trip = {ms_diff[28:0], 3'd0} + {ms_diff[30:0], 1'b0};

    trip = echo_sel ? echo_trip : te_trip;
  end

endmodule

>>> design/echo_reply_tracker.sv
// ----------------------------------------------------------------------------
// echo_reply_tracker
// Counts sent pings and received replies, flags duplicate echo replies
// through a bitmap and keeps round-trip minimum, maximum and sum.
// ----------------------------------------------------------------------------
// Flow: the edge that accepts an item also issues the bitmap read; when the
// update stage advances, the state is updated and the result register is
// loaded, and the result is offered from that register.
// Throughput: one item per cycle while results are taken; back-pressure on the output stalls the input.
// Reset: counters, maximum and sum clear and the minimum sets to all ones,
// then a pass over all DUP_WINDOW slots zeroes the bitmap while input ready
// is held low. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module echo_reply_tracker #(
  parameter int unsigned DUP_WINDOW = 1024
) (
  input logic          clk,
  input logic          rst_n,
  erc_stream_if.sink   in_if,
  erc_stream_if.source out_if,
  erc_stream_if.sink   cfg_if
);
  import erc_pkg::*;

  localparam int unsigned SW = $clog2(DUP_WINDOW);
  localparam logic [SW-1:0] LAST_SLOT = SW'(DUP_WINDOW - 1);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Configuration.
  logic [15:0] data_length_r;
  logic [15:0] own_ident_r;

  // Bitmap clearing pass.
  logic          clearing_r;
  logic [SW-1:0] clr_addr_r;

  // Update stage.
  logic          s1_valid_r;
  in_item_t      s1_item_r;
  logic [SW-1:0] s1_slot_r;

  // Last bitmap write, forwarded to a read that was issued at the same edge.
  logic          lw_valid_r;
  logic [SW-1:0] lw_addr_r;
  logic          lw_data_r;

  // Running state.
  logic [31:0]      sent_count_r,    sent_count_nxt;
  logic [31:0]      reply_count_r,   reply_count_nxt;
  logic [31:0]      repeat_count_r,  repeat_count_nxt;
  logic [31:0]      least_trip_r,    least_trip_nxt;
  logic [31:0]      greatest_trip_r, greatest_trip_nxt;
  logic [SUM_W-1:0] trip_total_r,    trip_total_nxt;

  // Result register.
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  logic          in_ready;
  logic          in_acc;
  logic          s1_adv;
  logic [SW-1:0] recv_slot;
  logic [SW-1:0] send_slot;
  logic          map_rdata;
  logic          seen_bit;
  logic          is_send;
  logic          len_ok;
  logic          is_echo;
  logic          is_te;
  logic          counted;
  logic          dup;
  logic [31:0]   trip_calc;
  logic [31:0]   trip;
  logic [SUM_W:0] sum_ext;
  logic [16:0]   need_len;
  logic          map_we;
  logic [SW-1:0] map_waddr;
  logic          map_wdata;
  logic          item_we;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_acc   = in_if.valid && in_ready;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_item_r;

  erc_slot #(.WINDOW(DUP_WINDOW)) u_recv_slot (
    .value (in_if.data.icmp_sequence),
    .slot  (recv_slot)
  );

  erc_slot #(.WINDOW(DUP_WINDOW)) u_send_slot (
    .value (sent_count_r[SEQ_W-1:0]),
    .slot  (send_slot)
  );

  erc_trip u_trip (
    .item     (s1_item_r),
    .echo_sel (is_echo),
    .trip     (trip_calc)
  );

  erc_ram #(.WIDTH(1), .DEPTH(DUP_WINDOW)) u_seen_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (in_acc),
    .raddr (recv_slot),
    .rdata (map_rdata)
  );

  always_comb begin
    seen_bit = (lw_valid_r && lw_addr_r == s1_slot_r) ? lw_data_r : map_rdata;

    need_len = {1'b0, data_length_r} + 17'(HEADER_BYTES);
    is_send  = s1_item_r.func == FUNC_SEND;
    len_ok   = {1'b0, s1_item_r.total_length} >= need_len;
    is_echo  = s1_item_r.msg_type == TYPE_ECHO_REPLY && s1_item_r.icmp_ident == own_ident_r;
    is_te    = s1_item_r.msg_type == TYPE_TIME_EXCEEDED;
    counted  = !is_send && len_ok && (is_echo || is_te);
    dup      = is_echo && seen_bit;
    trip     = counted ? trip_calc : 32'd0;

    sent_count_nxt    = sent_count_r;
    reply_count_nxt   = reply_count_r;
    repeat_count_nxt  = repeat_count_r;
    least_trip_nxt    = least_trip_r;
    greatest_trip_nxt = greatest_trip_r;
    trip_total_nxt    = trip_total_r;

    sum_ext = {1'b0, trip_total_r} + (SUM_W+1)'(trip);

    if (is_send) begin
      sent_count_nxt = sent_count_r + 32'd1;
    end else if (counted) begin
      trip_total_nxt = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      if (trip < least_trip_r) begin
        least_trip_nxt = trip;
      end
      if (trip > greatest_trip_r) begin
        greatest_trip_nxt = trip;
      end
      if (dup) begin
        repeat_count_nxt = repeat_count_r + 32'd1;
      end else begin
        reply_count_nxt = reply_count_r + 32'd1;
      end
    end

    if (is_send) begin
      out_item_nxt.status = STATUS_SENT;
    end else if (counted && dup) begin
      out_item_nxt.status = STATUS_DUPLICATE;
    end else if (counted) begin
      out_item_nxt.status = STATUS_ACCEPTED;
    end else begin
      out_item_nxt.status = STATUS_REJECTED;
    end
    out_item_nxt.trip_time       = trip;
    out_item_nxt.sent_sequence   = is_send ? sent_count_r[SEQ_W-1:0] : 16'd0;
    out_item_nxt.sent_total      = sent_count_nxt;
    out_item_nxt.received_total  = reply_count_nxt;
    out_item_nxt.duplicate_total = repeat_count_nxt;
    out_item_nxt.minimum_trip    = least_trip_nxt;
    out_item_nxt.maximum_trip    = greatest_trip_nxt;
    out_item_nxt.trip_sum        = trip_total_nxt;

    // A send clears its slot; a counted reply that is not a duplicate sets it.
    item_we   = s1_adv && (is_send || (counted && !dup));
    map_we    = clearing_r || item_we;
    map_waddr = clearing_r ? clr_addr_r : (is_send ? send_slot : s1_slot_r);
    map_wdata = !clearing_r && !is_send;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_length_r <= DATA_LENGTH_RESET;
      own_ident_r   <= OWN_IDENT_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.index)
        REG_DATA_LENGTH:    data_length_r <= cfg_if.data.value;
        REG_OWN_IDENTIFIER: own_ident_r   <= cfg_if.data.value;
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r      <= 1'b1;
      clr_addr_r      <= '0;
      s1_valid_r      <= 1'b0;
      lw_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      sent_count_r    <= '0;
      reply_count_r   <= '0;
      repeat_count_r  <= '0;
      least_trip_r    <= '1;
      greatest_trip_r <= '0;
      trip_total_r    <= '0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + SW'(1);
        if (clr_addr_r == LAST_SLOT) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (item_we) begin
        lw_valid_r <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_r     <= 1'b1;
        sent_count_r    <= sent_count_nxt;
        reply_count_r   <= reply_count_nxt;
        repeat_count_r  <= repeat_count_nxt;
        least_trip_r    <= least_trip_nxt;
        greatest_trip_r <= greatest_trip_nxt;
        trip_total_r    <= trip_total_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_if.data;
      s1_slot_r <= recv_slot;
    end
    if (item_we) begin
      lw_addr_r <= map_waddr;
      lw_data_r <= map_wdata;
    end
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
